// ===== rtl/lir_pkg.sv =====
// Package for the linear interpolation resampler: widths, fixed-point
// constants and the request payload structs. No dependencies.
`default_nettype none

package lir_pkg;

    // Sample and position formats
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int STEP_W      = FRAC_BITS + 3;
    localparam int OFS_W       = FRAC_BITS + 3;
    localparam int PROD_W      = SAMPLE_BITS + FRAC_BITS + 2;

    // Position of one input sample, and the step limits of 0.25 and 4.0
    localparam logic [OFS_W-1:0]  ONE_POS    = OFS_W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(1) << (FRAC_BITS - 2);
    localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(4) << FRAC_BITS;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << FRAC_BITS;

    // Rounding bias: one half in the product format
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          end_of_stream;
    } lir_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          run_last;
        logic                          stream_done;
    } lir_out_t;

endpackage

`default_nettype wire

// ===== rtl/linear_interp_resampler.sv =====
// Linear interpolation sample-rate converter, top level.
// Depends on lir_pkg for widths, constants and payload structs.
//
// Usage:
//   Input requests (s_valid/s_ready, s_data) carry one signed sample and an
//   end-of-stream flag. Result requests (m_valid/m_ready, m_data) carry one
//   interpolated sample with run_last and stream_done. The step ratio
//   register (cfg_we/cfg_wdata, 16 fraction bits) is clamped to 0.25 .. 4.0
//   on use; the user must write it only while the block is idle (unenforced).
// Sequencing:
//   One input at a time; s_ready is high only in the idle state. Each
//   interpolated result passes the step, round and output states, and each
//   end-of-stream repeat the step and output states; a last pass through
//   the step state closes the input. A held first sample yields no result.
//   One multiplier serves all results, and each result waits in the result
//   register. An input yields up to 4 interpolated results; with end of
//   stream up to 8 results in all.
// Reset and stall:
//   Synchronous active-low reset returns to idle, clears the stream state
//   and sets the step ratio to 1.0. A stalled receiver holds the result
//   register; the sequencer waits and takes no new input meanwhile.
`default_nettype none

module linear_interp_resampler
    import lir_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input requests
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire lir_in_t           s_data,
    // result requests
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lir_out_t               m_data,
    // step ratio register
    input  wire logic              cfg_we,
    input  wire logic [STEP_W-1:0] cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_ROUND,
        ST_OUT
    } state_t;

    state_t                        state_reg,   state_next;
    logic [STEP_W-1:0]             ratio_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg,    prev_next;
    logic signed [SAMPLE_BITS-1:0] cur_reg,     cur_next;
    logic                          eos_reg,     eos_next;
    logic                          have_reg,    have_next;
    logic                          tail_reg,    tail_next;
    logic [OFS_W-1:0]              ofs_reg,     ofs_next;
    logic signed [PROD_W-1:0]      prod_reg,    prod_next;
    logic                          m_valid_reg, m_valid_next;
    lir_out_t                      out_reg,     out_next;

    logic [STEP_W-1:0]             step_w;
    logic [OFS_W-1:0]              ofs_sum;
    logic                          ofs_ge_one;
    logic                          sum_ge_one;
    logic                          sum_lt_two;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [FRAC_BITS:0]     frac;
    logic signed [PROD_W-1:0]      prod_rnd;
    logic                          last_interp;

    // Clamp the step ratio to its usable range
    always_comb begin
        if (ratio_reg < STEP_MIN) begin
            step_w = STEP_MIN;
        end else if (ratio_reg > STEP_MAX) begin
            step_w = STEP_MAX;
        end else begin
            step_w = ratio_reg;
        end
    end

    // Shared datapath: position advance, difference, product and rounding
    assign ofs_sum     = ofs_reg + OFS_W'(step_w);
    assign ofs_ge_one  = |ofs_reg[OFS_W-1:FRAC_BITS];
    assign sum_ge_one  = |ofs_sum[OFS_W-1:FRAC_BITS];
    assign sum_lt_two  = ~|ofs_sum[OFS_W-1:FRAC_BITS+1];
    assign diff        = {cur_reg[SAMPLE_BITS-1], cur_reg}
                       - {prev_reg[SAMPLE_BITS-1], prev_reg};
    assign frac        = {1'b0, ofs_reg[FRAC_BITS-1:0]};
    assign prod_rnd    = prod_reg + ROUND_HALF;
    // last interpolated result unless an end-of-stream repeat follows
    assign last_interp = sum_ge_one && !(eos_reg && sum_lt_two);

    // Sequencer next-state and datapath control
    always_comb begin
        state_next   = state_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        eos_next     = eos_reg;
        have_next    = have_reg;
        tail_next    = tail_reg;
        ofs_next     = ofs_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cur_next = s_data.sample_in;
                    eos_next = s_data.end_of_stream;
                    if (have_reg) begin
                        tail_next  = 1'b0;
                        state_next = ST_STEP;
                    end else if (s_data.end_of_stream) begin
                        tail_next  = 1'b1;
                        state_next = ST_STEP;
                    end else begin
                        // first sample of a stream: hold it, no result yet
                        prev_next = s_data.sample_in;
                        have_next = 1'b1;
                    end
                end
            end
            ST_STEP: begin
                if (!ofs_ge_one) begin
                    if (tail_reg) begin
                        // repeat the final sample up to the stream length
                        out_next.sample_out  = cur_reg;
                        out_next.run_last    = sum_ge_one;
                        out_next.stream_done = sum_ge_one;
                        ofs_next             = ofs_sum;
                        m_valid_next         = 1'b1;
                        state_next           = ST_OUT;
                    end else begin
                        prod_next  = PROD_W'(diff * frac);
                        state_next = ST_ROUND;
                    end
                end else if (tail_reg) begin
                    // drop the stream state after the final sample
                    prev_next  = '0;
                    ofs_next   = '0;
                    have_next  = 1'b0;
                    tail_next  = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    // advance to the next input interval
                    ofs_next  = ofs_reg - ONE_POS;
                    prev_next = cur_reg;
                    have_next = 1'b1;
                    if (eos_reg) begin
                        tail_next = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ROUND: begin
                out_next.sample_out  = prev_reg + prod_rnd[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
                out_next.run_last    = last_interp;
                out_next.stream_done = last_interp && eos_reg;
                ofs_next             = ofs_sum;
                m_valid_next         = 1'b1;
                state_next           = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_STEP;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, stream state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ratio_reg   <= STEP_RESET;
            prev_reg    <= '0;
            have_reg    <= 1'b0;
            tail_reg    <= 1'b0;
            eos_reg     <= 1'b0;
            ofs_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            prev_reg    <= prev_next;
            have_reg    <= have_next;
            tail_reg    <= tail_next;
            eos_reg     <= eos_next;
            ofs_reg     <= ofs_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                ratio_reg <= cfg_wdata;
            end
        end
        cur_reg  <= cur_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Result register is only loaded on the way into the output state
    a_valid_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg == (state_reg == ST_OUT))
        else $error("result valid out of step with sequencer");

    // Stream end is always also the end of a run
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.stream_done |-> m_data.run_last)
        else $error("stream_done without run_last");

    // Interpolation only runs with a fraction inside the current interval
    a_round_frac: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROUND |-> !ofs_ge_one && !tail_reg)
        else $error("interpolation outside the interval");

    // A first sample without end of stream is held and the block stays idle
    a_first_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !have_reg && !s_data.end_of_stream
        |=> have_reg && s_ready && !m_valid)
        else $error("first sample not held");

    // A finished stream leaves the stream state cleared
    a_stream_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.stream_done |=> ##[1:2] (!have_reg && s_ready))
        else $error("stream state not cleared after final result");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for linear_interp_resampler: a table of directed requests, then random streams
// under several step ratios and idling patterns, results checked against a local model and typed-in samples.
// Depends on lir_pkg and the linear_interp_resampler RTL.
`default_nettype none

module tb_top;
    import lir_pkg::*;

    localparam int          CLK_PERIOD  = 10;
    localparam int          RESET_LEN   = 9;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          SETTLE      = 30;
    localparam int          PHASE_ITEMS = 34;
    localparam int          RESULT_CAP  = 8;
    localparam int          PRINT_CAP   = 30;
    localparam int unsigned POS_ONE     = ONE_POS;

    // Idling patterns of the random phases
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One directed request; want is the typed-in sample of every result where known is set
    typedef struct packed {
        logic [STEP_W-1:0]             step;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          eos;
        logic                          known;
        logic signed [SAMPLE_BITS-1:0] want;
    } dir_row_t;

    localparam int DIR_N = 24;

    dir_row_t dir_tab [DIR_N] = '{
        // unity step: first sample, samples landing on positions, end of stream
        '{19'h10000, 16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
        '{19'h10000, 16'sh8000, 1'b0, 1'b1, 16'sh7FFF},
        '{19'h10000, 16'sh7FFF, 1'b0, 1'b1, 16'sh8000},
        '{19'h10000, 16'sh0000, 1'b1, 1'b0, 16'sh0000},
        '{19'h10000, 16'sh5555, 1'b1, 1'b1, 16'sh5555},
        // half step: rounding of halves toward plus infinity
        '{19'h08000, 16'shFFFF, 1'b0, 1'b0, 16'sh0000},
        '{19'h08000, 16'sh0000, 1'b0, 1'b0, 16'sh0000},
        '{19'h08000, 16'sh0001, 1'b0, 1'b0, 16'sh0000},
        '{19'h08000, 16'sh8000, 1'b1, 1'b0, 16'sh0000},
        // zero step clamps to a quarter: four results, then eight on the end
        '{19'h00000, 16'sh1234, 1'b0, 1'b0, 16'sh0000},
        '{19'h00000, 16'shFC18, 1'b0, 1'b0, 16'sh0000},
        '{19'h00000, 16'sh7FFF, 1'b1, 1'b0, 16'sh0000},
        // full-scale step clamps to four: skipped inputs, end with no results
        '{19'h7FFFF, 16'sh0100, 1'b0, 1'b0, 16'sh0000},
        '{19'h7FFFF, 16'sh0200, 1'b0, 1'b1, 16'sh0100},
        '{19'h7FFFF, 16'sh0300, 1'b0, 1'b0, 16'sh0000},
        '{19'h7FFFF, 16'sh0400, 1'b1, 1'b0, 16'sh0000},
        // exact lower limit
        '{19'h04000, 16'sh8000, 1'b0, 1'b0, 16'sh0000},
        '{19'h04000, 16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
        '{19'h04000, 16'sh8000, 1'b1, 1'b0, 16'sh0000},
        // exact upper limit
        '{19'h40000, 16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
        '{19'h40000, 16'sh8000, 1'b1, 1'b1, 16'sh7FFF},
        // step of one and a half
        '{19'h18000, 16'sh4000, 1'b0, 1'b0, 16'sh0000},
        '{19'h18000, 16'shC000, 1'b0, 1'b0, 16'sh0000},
        '{19'h18000, 16'sh2000, 1'b1, 1'b0, 16'sh0000}
    };

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    lir_in_t           s_data;
    logic              m_valid;
    logic              m_ready;
    lir_out_t          m_data;
    logic              cfg_we;
    logic [STEP_W-1:0] cfg_wdata;

    // Model state and register copy
    logic [STEP_W-1:0]             step_reg;
    logic signed [SAMPLE_BITS-1:0] prev_smp;
    int unsigned                   read_pos;
    bit                            have_prev;

    lir_out_t batch_q [$];
    lir_out_t result_q [$];

    int err_cnt   = 0;
    int cycle_cnt = 0;
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_req  = 0;

    linear_interp_resampler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_fault(input string what, input int got, input int want);
        err_cnt++;
        if (err_cnt <= PRINT_CAP)
            $display("cycle %0d: %s: got %0d, want %0d", cycle_cnt, what, got, want);
    endtask

    function automatic int unsigned clamped_step();
        if (step_reg < STEP_MIN)
            return STEP_MIN;
        if (step_reg > STEP_MAX)
            return STEP_MAX;
        return step_reg;
    endfunction

    // Blend two samples at fraction f, exact sum, halves rounded upward
    function automatic logic signed [SAMPLE_BITS-1:0] lerp_sample(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b,
        input int unsigned                   f
    );
        longint acc;
        acc = longint'(a) * longint'(POS_ONE - f) + longint'(b) * longint'(f);
        return SAMPLE_BITS'((acc + longint'(ROUND_HALF)) >>> FRAC_BITS);
    endfunction

    // Work out the results of one request into batch_q and advance the stream state
    function automatic void predict_resample(input lir_in_t req);
        lir_out_t    r;
        int unsigned stp;
        stp = clamped_step();
        r.run_last    = 1'b0;
        r.stream_done = 1'b0;
        if (have_prev) begin
            while (read_pos < POS_ONE && batch_q.size() < RESULT_CAP) begin
                r.sample_out = lerp_sample(prev_smp, req.sample_in, read_pos);
                batch_q.push_back(r);
                read_pos += stp;
            end
            if (read_pos >= POS_ONE)
                read_pos -= POS_ONE;
            else
                read_pos = 0;
        end
        prev_smp  = req.sample_in;
        have_prev = 1'b1;

        // Repeat the final sample up to the stream length
        if (req.end_of_stream) begin
            while (read_pos < POS_ONE && batch_q.size() < RESULT_CAP) begin
                r.sample_out = req.sample_in;
                batch_q.push_back(r);
                read_pos += stp;
            end
            prev_smp  = '0;
            read_pos  = 0;
            have_prev = 1'b0;
        end

        // Flag the last result of this request
        if (batch_q.size() != 0) begin
            r             = batch_q.pop_back();
            r.run_last    = 1'b1;
            r.stream_done = req.end_of_stream;
            batch_q.push_back(r);
        end
    endfunction

    // Offer one request from a falling edge; return at the falling edge after acceptance
    task automatic send_req(input lir_in_t req, input bit known,
                            input logic signed [SAMPLE_BITS-1:0] want);
        lir_out_t r;
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_resample(req);
        while (batch_q.size() != 0) begin
            r = batch_q.pop_front();
            if (known)
                r.sample_out = want;
            result_q.push_back(r);
        end
        @(negedge aclk);
    endtask

    // Drop valid, drain every expected result, then let a request with no result finish
    task automatic wait_idle();
        s_valid = 1'b0;
        while (result_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] v);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        step_reg  = v;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(4))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                3:       return 16'shFFFF;
                default: return 16'sh0001;
            endcase
        end
        return SAMPLE_BITS'($urandom);
    endfunction

    // Result side: random stalls, and a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        lir_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                report_fault("result with nothing expected", int'(m_data.sample_out), 0);
            end else begin
                want = result_q.pop_front();
                if (m_data.sample_out !== want.sample_out)
                    report_fault("sample_out", int'(m_data.sample_out), int'(want.sample_out));
                if (m_data.run_last !== want.run_last)
                    report_fault("run_last", int'(m_data.run_last), int'(want.run_last));
                if (m_data.stream_done !== want.stream_done)
                    report_fault("stream_done", int'(m_data.stream_done),
                                 int'(want.stream_done));
            end
        end
    end

    // Stimulus
    initial begin
        lir_in_t           req;
        logic [STEP_W-1:0] phase_step [6];
        idle_mode_t        mode;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        step_reg  = STEP_RESET;
        prev_smp  = '0;
        read_pos  = 0;
        have_prev = 1'b0;

        // Hold reset, then release on a falling edge
        repeat (RESET_LEN) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Walk the directed table, changing the step only once the block is idle
        for (int i = 0; i < DIR_N; i++) begin
            if (dir_tab[i].step != step_reg) begin
                wait_idle();
                write_step(dir_tab[i].step);
            end
            req.sample_in     = dir_tab[i].smp;
            req.end_of_stream = dir_tab[i].eos;
            send_req(req, dir_tab[i].known, dir_tab[i].want);
        end

        // Random phases: limits, out-of-range values and random steps
        phase_step[0] = STEP_MIN;
        phase_step[1] = STEP_MAX;
        phase_step[2] = '0;
        phase_step[3] = '1;
        phase_step[4] = STEP_W'($urandom_range(int'(STEP_MAX), int'(STEP_MIN)));
        phase_step[5] = STEP_W'($urandom);

        for (int p = 0; p < 6; p++) begin
            wait_idle();
            write_step(phase_step[p]);
            mode = idle_mode_t'(p % 4);
            case (mode)
                IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
                IDLE_SENDER:   begin idle_pct = 81; stall_pct = 0;  end
                IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 81; end
                default:       begin idle_pct = 6;  stall_pct = 6;  end
            endcase
            // Hold off the receiver while the sender keeps offering
            if (p == 4)
                hold_req = 300;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                req.sample_in     = rand_sample();
                req.end_of_stream = ($urandom_range(5) == 0);
                send_req(req, 1'b0, '0);
            end
        end

        wait_idle();
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/lir_pkg.sv
rtl/linear_interp_resampler.sv
tb/tb_top.sv
